/* rtl/core/assert_macros.svh */
// Assertion helpers used by the RTL. Each use names a label, the clock,
// the active-low reset, an antecedent, a consequent and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define RCM_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RCM_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/rcm_pkg.sv */
`timescale 1ns / 1ps

package rcm_pkg;

    localparam int NUM_ROTORS    = 3;
    localparam int NUM_LETTERS   = 26;
    // plug in, rotors forward, reflector, rotors backward, plug out
    localparam int LOOKUPS       = 2 * NUM_ROTORS + 3;

    localparam logic [2:0] CMD_ENCODE    = 3'd0;
    localparam logic [2:0] CMD_ROTOR     = 3'd1;
    localparam logic [2:0] CMD_REFL      = 3'd2;
    localparam logic [2:0] CMD_PLUG      = 3'd3;
    localparam logic [2:0] CMD_SETPOS    = 3'd4;

    localparam logic CFG_NOTCH_RIGHT     = 1'b0;
    localparam logic CFG_NOTCH_MIDDLE    = 1'b1;

    localparam logic [4:0] NOTCH_RIGHT_RST  = 5'd21;
    localparam logic [4:0] NOTCH_MIDDLE_RST = 5'd4;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

    typedef enum logic [2:0] {
        OP_LETTER,
        OP_PASS,
        OP_ROTOR,
        OP_REFL,
        OP_PLUG,
        OP_SETPOS
    } op_t;

    typedef struct packed {
        logic [2:0] command;
        logic [1:0] rotor_sel;
        logic [4:0] table_index;
        logic [4:0] table_value;
        logic [7:0] char_in;
    } in_item_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       not_letter;
    } out_item_t;

    // Classified item as it sits in the queue between front and back.
    typedef struct packed {
        op_t        op;
        logic [1:0] sel;
        logic [4:0] idx;
        logic [4:0] val;
        logic [7:0] ch;
    } q_item_t;

    // (w + a - s) mod 26 for operands already below 26.
    function automatic logic [4:0] mod_add_sub(input logic [4:0] w,
                                               input logic [4:0] a,
                                               input logic [4:0] s);
        logic [5:0] t;
        t = {1'b0, w} + {1'b0, a};
        if (t >= 6'(NUM_LETTERS))
            t = t - 6'(NUM_LETTERS);
        if (t[4:0] >= s)
            return t[4:0] - s;
        return 5'(t + 6'(NUM_LETTERS) - {1'b0, s});
    endfunction

endpackage

/* rtl/core/rcm_fifo.sv */
`timescale 1ns / 1ps

module rcm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

/* rtl/core/rcm_front.sv */
`timescale 1ns / 1ps

module rcm_front (
    input  logic              push,
    input  rcm_pkg::in_item_t item,
    output logic              full,
    input  logic              q_full,
    output logic              q_push,
    output rcm_pkg::q_item_t  q_item
);

    logic keep;
    logic ok;
    logic upper, lower;

    assign ok    = (item.table_index < 5'(rcm_pkg::NUM_LETTERS))
                && (item.table_value < 5'(rcm_pkg::NUM_LETTERS));
    assign upper = (item.char_in >= rcm_pkg::CHAR_UPPER_A)
                && (item.char_in <= rcm_pkg::CHAR_UPPER_Z);
    assign lower = (item.char_in >= rcm_pkg::CHAR_LOWER_A)
                && (item.char_in <= rcm_pkg::CHAR_LOWER_Z);

    // Classify; commands that would be ignored are accepted and dropped here.
    always_comb
    begin
        q_item.op  = rcm_pkg::OP_PASS;
        q_item.sel = item.rotor_sel;
        q_item.idx = item.table_index;
        q_item.val = item.table_value;
        q_item.ch  = item.char_in;
        keep       = 1'b0;
        case (item.command)
            rcm_pkg::CMD_ENCODE:
            begin
                keep = 1'b1;
                if (upper || lower)
                begin
                    q_item.op  = rcm_pkg::OP_LETTER;
                    // both cases sit at 1..26 in the low five bits
                    q_item.idx = item.char_in[4:0] - 5'd1;
                end
            end
            rcm_pkg::CMD_ROTOR:
            begin
                q_item.op = rcm_pkg::OP_ROTOR;
                keep      = ok && (item.rotor_sel < 2'(rcm_pkg::NUM_ROTORS));
            end
            rcm_pkg::CMD_REFL:
            begin
                q_item.op = rcm_pkg::OP_REFL;
                keep      = ok;
            end
            rcm_pkg::CMD_PLUG:
            begin
                q_item.op = rcm_pkg::OP_PLUG;
                keep      = ok;
            end
            rcm_pkg::CMD_SETPOS:
            begin
                q_item.op = rcm_pkg::OP_SETPOS;
                keep      = (item.rotor_sel < 2'(rcm_pkg::NUM_ROTORS))
                         && (item.table_value < 5'(rcm_pkg::NUM_LETTERS));
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign full   = q_full;
    assign q_push = push && !q_full && keep;

endmodule

/* rtl/core/rcm_back.sv */
`timescale 1ns / 1ps

module rcm_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [4:0]         notch_right,
    input  logic [4:0]         notch_middle,
    input  rcm_pkg::q_item_t   q_item,
    input  logic               q_empty,
    output logic               q_pop,
    output rcm_pkg::out_item_t res_item,
    output logic               res_push,
    input  logic               res_full
);

    localparam int NL = rcm_pkg::LOOKUPS;
    localparam int RC = rcm_pkg::NUM_ROTORS;

    typedef struct packed {
        rcm_pkg::op_t          op;
        logic [1:0]            sel;
        logic [4:0]            idx;
        logic [4:0]            val;
        logic [7:0]            ch;
        logic [4:0]            e;
        logic [RC-1:0][4:0]    pos;
    } stage_t;

    logic [RC-1:0][4:0] pos_reg, pos_next;
    stage_t             st_reg  [NL+1];
    stage_t             st_next [NL+1];
    logic               vld_reg [NL+1];
    logic               en;
    logic               last_is_result;

    assign last_is_result = (st_reg[NL].op == rcm_pkg::OP_LETTER)
                         || (st_reg[NL].op == rcm_pkg::OP_PASS);
    // Freeze the whole pipe only when the last stage cannot hand off.
    assign en       = !(vld_reg[NL] && last_is_result && res_full);
    assign q_pop    = en && !q_empty;
    assign res_push = en && vld_reg[NL] && last_is_result;
    assign res_item.char_out   = st_reg[NL].ch;
    assign res_item.not_letter = (st_reg[NL].op == rcm_pkg::OP_PASS);

    // Step stage: rotor motion and position loads.
    always_comb
    begin
        logic mid_at, right_at;
        mid_at   = (pos_reg[1] == notch_middle);
        right_at = (pos_reg[0] == notch_right);
        pos_next = pos_reg;
        case (q_item.op)
            rcm_pkg::OP_LETTER:
            begin
                pos_next[0] = rcm_pkg::mod_add_sub(pos_reg[0], 5'd1, 5'd0);
                if (right_at || mid_at)
                    pos_next[1] = rcm_pkg::mod_add_sub(pos_reg[1], 5'd1, 5'd0);
                if (mid_at)
                    pos_next[2] = rcm_pkg::mod_add_sub(pos_reg[2], 5'd1, 5'd0);
            end
            rcm_pkg::OP_SETPOS:
            begin
                pos_next[q_item.sel] = q_item.val;
            end
            default:
            begin
                pos_next = pos_reg;
            end
        endcase
        st_next[0].op  = q_item.op;
        st_next[0].sel = q_item.sel;
        st_next[0].idx = q_item.idx;
        st_next[0].val = q_item.val;
        st_next[0].ch  = q_item.ch;
        st_next[0].e   = q_item.idx;
        st_next[0].pos = pos_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pos_reg <= '0;
        else if (q_pop)
            pos_reg <= pos_next;
    end

    // One table per stage; commands write a table as they pass its stage,
    // so every table sees reads and writes in arrival order.
    for (genvar k = 0; k < NL; k++)
    begin : g_lookup
        logic [4:0] tbl_reg [rcm_pkg::NUM_LETTERS];
        logic [4:0] w, add_v, sub_v;
        logic       wa_en, wb_en, wr_ok;
        stage_t     cur;

        assign cur   = st_reg[k];
        assign wr_ok = en && vld_reg[k];
        assign w     = tbl_reg[cur.e];

        always_comb
        begin
            wa_en = 1'b0;
            wb_en = 1'b0;
            if (wr_ok)
            begin
                if (k == 0 || k == NL - 1)
                begin
                    wa_en = (cur.op == rcm_pkg::OP_PLUG);
                    wb_en = (cur.op == rcm_pkg::OP_PLUG);
                end
                else if (k <= RC)
                    wa_en = (cur.op == rcm_pkg::OP_ROTOR) && (cur.sel == 2'(k - 1));
                else if (k == RC + 1)
                    wa_en = (cur.op == rcm_pkg::OP_REFL);
                else
                    wb_en = (cur.op == rcm_pkg::OP_ROTOR) && (cur.sel == 2'(NL - 2 - k));
            end
        end

        // Shift between rotor frames: enter next table at (w + add - sub) mod 26.
        always_comb
        begin
            add_v = 5'd0;
            sub_v = 5'd0;
            case (k)
                0: begin add_v = cur.pos[0]; sub_v = 5'd0;       end
                1: begin add_v = cur.pos[1]; sub_v = cur.pos[0]; end
                2: begin add_v = cur.pos[2]; sub_v = cur.pos[1]; end
                3: begin add_v = 5'd0;       sub_v = cur.pos[2]; end
                4: begin add_v = cur.pos[2]; sub_v = 5'd0;       end
                5: begin add_v = cur.pos[1]; sub_v = cur.pos[2]; end
                6: begin add_v = cur.pos[0]; sub_v = cur.pos[1]; end
                7: begin add_v = 5'd0;       sub_v = cur.pos[0]; end
                default: begin add_v = 5'd0; sub_v = 5'd0;       end
            endcase
            st_next[k+1]   = cur;
            st_next[k+1].e = rcm_pkg::mod_add_sub(w, add_v, sub_v);
            if (k == NL - 1 && cur.op == rcm_pkg::OP_LETTER)
                st_next[k+1].ch = {cur.ch[7:5], w + 5'd1};
        end

        if (k == 0 || k == NL - 1)
        begin : g_plug
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    for (int i = 0; i < rcm_pkg::NUM_LETTERS; i++)
                        tbl_reg[i] <= 5'(i);
                end
                else
                begin
                    if (wa_en)
                        tbl_reg[cur.idx] <= cur.val;
                    if (wb_en)
                        tbl_reg[cur.val] <= cur.idx;
                end
            end
        end
        else
        begin : g_wire
            always_ff @(posedge clk)
            begin
                if (wa_en)
                    tbl_reg[cur.idx] <= cur.val;
                if (wb_en)
                    tbl_reg[cur.val] <= cur.idx;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NL; i++)
                vld_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= !q_empty;
            for (int i = 1; i <= NL; i++)
                vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i <= NL; i++)
                st_reg[i] <= st_next[i];
        end
    end

endmodule

/* rtl/core/rotor_cipher_machine_unit.sv */
`timescale 1ns / 1ps

// Three-rotor cipher with plugboard and reflector, no ring settings. Push an
// item while full is low; one item is taken every cycle, and results leave
// in order through empty/pop, one beat per letter or pass-through character.
// A letter steps the rotors (right always, middle at notch_right or on the
// double step at notch_middle, left at notch_middle), runs through plugboard,
// rotors, reflector, rotors back and plugboard, and comes out in its input
// case. Other characters come out unchanged with not_letter set and leave
// the rotors alone. Load and position commands give no result; ones with an
// operand out of range, and unknown commands, are dropped. A classified item
// waits in a short queue, then moves through a step stage and one stage per
// table lookup (nine) before it reaches the result queue; throughput is one
// item per cycle, set by the lookup pipeline, which stalls only when the
// result queue is full. Rotor and reflector tables hold nothing useful until
// loaded; the plugboard comes out of reset as identity, positions as AAA.
// Write the notch registers only while idle.
module rotor_cipher_machine_unit #(
    parameter int QUEUE_DEPTH  = 4,
    parameter int RESULT_DEPTH = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  rcm_pkg::in_item_t  item,
    output logic               full,
    output logic               empty,
    input  logic               pop,
    output rcm_pkg::out_item_t result,
    input  logic               cfg_write,
    input  logic               cfg_index,
    input  logic [4:0]         cfg_data
);

`include "assert_macros.svh"

    logic [4:0]         notch_right_reg, notch_middle_reg;
    logic               q_push, q_full, q_empty, q_pop;
    rcm_pkg::q_item_t   q_in, q_out;
    rcm_pkg::out_item_t res_in;
    logic               res_push, res_full;

    // Notch registers: plain writes, no read-back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            notch_right_reg  <= rcm_pkg::NOTCH_RIGHT_RST;
            notch_middle_reg <= rcm_pkg::NOTCH_MIDDLE_RST;
        end
        else if (cfg_write)
        begin
            if (cfg_index == rcm_pkg::CFG_NOTCH_RIGHT)
                notch_right_reg <= cfg_data;
            else
                notch_middle_reg <= cfg_data;
        end
    end

    // Front: classify and drop ignored commands.
    rcm_front u_front (
        .push   (push),
        .item   (item),
        .full   (full),
        .q_full (q_full),
        .q_push (q_push),
        .q_item (q_in)
    );

    // Queue between front and back.
    rcm_fifo #(
        .WIDTH ($bits(rcm_pkg::q_item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_in),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_out),
        .empty (q_empty)
    );

    // Back: stepping and the lookup pipeline.
    rcm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .notch_right  (notch_right_reg),
        .notch_middle (notch_middle_reg),
        .q_item       (q_out),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .res_item     (res_in),
        .res_push     (res_push),
        .res_full     (res_full)
    );

    // Result queue: holds finished beats while the consumer stalls.
    rcm_fifo #(
        .WIDTH ($bits(rcm_pkg::out_item_t)),
        .DEPTH (RESULT_DEPTH)
    ) u_result (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

    // Back end must never push into a full result queue.
    `RCM_ASSERT_IMP(a_res_no_overflow, clk, rst_n, res_push, !res_full,
                    "result push while full")
    // Back end must never take from an empty queue.
    `RCM_ASSERT_IMP(a_q_no_underflow, clk, rst_n, q_pop, !q_empty,
                    "queue pop while empty")
    // A notch write lands in the register the index names.
    `RCM_ASSERT_NXT(a_notch_right_wr, clk, rst_n,
                    cfg_write && (cfg_index == rcm_pkg::CFG_NOTCH_RIGHT),
                    notch_right_reg == $past(cfg_data), "notch_right write lost")
    `RCM_ASSERT_NXT(a_notch_mid_wr, clk, rst_n,
                    cfg_write && (cfg_index == rcm_pkg::CFG_NOTCH_MIDDLE),
                    notch_middle_reg == $past(cfg_data), "notch_middle write lost")

endmodule
